// ----- rtl/gsps_pkg.sv -----
// package: widths, constants, register indexes and gain tables of the pid servo
package gsps_pkg;

  localparam int ADC_BITS      = 10;
  localparam int FRACTION_BITS = 8;

  localparam int FULLSCALE = (1 << ADC_BITS) - 1;
  localparam int DIST_OFFSET = 57 << (FRACTION_BITS - 1);

  localparam int MA_W   = 32;
  localparam int MB_W   = 18;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int DEN_W  = 17;
  localparam int DIV_W  = (ADC_BITS + FRACTION_BITS + 8 > 33) ?
                          ADC_BITS + FRACTION_BITS + 8 : 33;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam int DER_W  = 28;
  localparam int GAIN_SHIFT = 12;

  // reciprocals of the full scale and of 125, scaled by 2^36, split in 16-bit halves
  localparam int     RCP_SHIFT = 36;
  localparam int     RCP_DROP  = RCP_SHIFT - 16;
  localparam int     RCPN_W    = 29;
  localparam longint RCP_FS    = ((longint'(1) << RCP_SHIFT) + FULLSCALE - 1) / FULLSCALE;
  localparam longint RCP_SEC   = ((longint'(1) << RCP_SHIFT) + 124) / 125;
  localparam logic [15:0] RCP_FS_HI  = 16'(RCP_FS >> 16);
  localparam logic [15:0] RCP_FS_LO  = 16'(RCP_FS);
  localparam logic [15:0] RCP_SEC_HI = 16'(RCP_SEC >> 16);
  localparam logic [15:0] RCP_SEC_LO = 16'(RCP_SEC);

  localparam logic [2:0] REG_SETPOINT   = 3'd0;
  localparam logic [2:0] REG_DEADBAND   = 3'd1;
  localparam logic [2:0] REG_INT_LIMIT  = 3'd2;
  localparam logic [2:0] REG_CENTER     = 3'd3;
  localparam logic [2:0] REG_SERVO_LOW  = 3'd4;
  localparam logic [2:0] REG_SERVO_HIGH = 3'd5;
  localparam logic [2:0] REG_SONAR_SM   = 3'd6;
  localparam logic [2:0] REG_SERVO_SM   = 3'd7;

  localparam logic [1:0] ZONE_NEAR = 2'd0;
  localparam logic [1:0] ZONE_MID  = 2'd1;
  localparam logic [1:0] ZONE_FAR  = 2'd2;

  function automatic logic [13:0] gain_kp(input logic [1:0] zone);
    unique case (zone)
      ZONE_FAR: gain_kp = 14'd6554;
      ZONE_MID: gain_kp = 14'd2458;
      default:  gain_kp = 14'd1638;
    endcase
  endfunction

  function automatic logic [13:0] gain_ki(input logic [1:0] zone);
    unique case (zone)
      ZONE_FAR: gain_ki = 14'd0;
      ZONE_MID: gain_ki = 14'd205;
      default:  gain_ki = 14'd410;
    endcase
  endfunction

  function automatic logic [13:0] gain_kd(input logic [1:0] zone);
    unique case (zone)
      ZONE_FAR: gain_kd = 14'd7782;
      ZONE_MID: gain_kd = 14'd1638;
      default:  gain_kd = 14'd819;
    endcase
  endfunction

endpackage

// ----- rtl/gain_scheduled_pid_servo.sv -----
// gain-scheduled pid servo controller: sequencer around one multiplier and one divider
//
// input channel: in_valid/in_ready carry one item, adc_sample and elapsed_ms.
// output channel: out_valid/out_ready carry servo_angle, filtered_distance,
// control_error, pid_output and gain_zone.
// config port: cfg_write, cfg_index, cfg_data; write only while idle.
// an item with elapsed_ms zero is taken and gives no result.
// an item runs from acceptance to result through two reciprocal
// multiplications (distance scaling, integral step), one divide at one
// quotient bit per cycle (derivative) and 20 multiply and
// update steps on the shared multiplier; in_ready is high only while the
// sequencer is idle, so a new item is taken only after the last result is stored.
// a finished result sits in the output register; the next item is accepted
// meanwhile and its work stops at the last step until the receiver takes
// the earlier result.
// synchronous reset loads the register defaults, clears the filter, integral
// and derivative history and empties the output register.
module gain_scheduled_pid_servo import gsps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [9:0]         adc_sample,
  input  logic [15:0]        elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         servo_angle,
  output logic [15:0]        filtered_distance,
  output logic signed [16:0] control_error,
  output logic signed [23:0] pid_output,
  output logic [1:0]         gain_zone
);

  typedef enum logic [25:0] {
    S_IDLE     = 26'd1 << 0,
    S_RAW_MUL  = 26'd1 << 1,
    S_RAW_DIV  = 26'd1 << 2,
    S_DIV      = 26'd1 << 3,
    S_SD_MUL1  = 26'd1 << 4,
    S_SD_MUL2  = 26'd1 << 5,
    S_SD_ADD   = 26'd1 << 6,
    S_SD_UPD   = 26'd1 << 7,
    S_ERR      = 26'd1 << 8,
    S_INT_MUL  = 26'd1 << 9,
    S_INT_DIV  = 26'd1 << 10,
    S_INT_UPD  = 26'd1 << 11,
    S_DER_DIV  = 26'd1 << 12,
    S_PID_P    = 26'd1 << 13,
    S_PID_I    = 26'd1 << 14,
    S_PID_D    = 26'd1 << 15,
    S_PID_ADD  = 26'd1 << 16,
    S_PID_SAT  = 26'd1 << 17,
    S_CMD_MUL1 = 26'd1 << 18,
    S_CMD_MUL2 = 26'd1 << 19,
    S_CMD_ADD  = 26'd1 << 20,
    S_OUT      = 26'd1 << 21,
    S_RCP_HI   = 26'd1 << 22,
    S_RCP_LO   = 26'd1 << 23,
    S_RCP_ADD  = 26'd1 << 24,
    S_RCP_END  = 26'd1 << 25
  } state_t;

  localparam logic signed [ACC_W-1:0] DIST_MIN = ACC_W'(20 << FRACTION_BITS);
  localparam logic signed [ACC_W-1:0] DIST_MAX = ACC_W'(220 << FRACTION_BITS);
  localparam logic signed [ACC_W-1:0] PID_MAX  = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] PID_MIN  = -ACC_W'(8388608);
  localparam logic [16:0] ZONE_FAR_MAG = 17'(10 << FRACTION_BITS);
  localparam logic [16:0] ZONE_MID_MAG = 17'(5 << FRACTION_BITS);

  // configuration
  logic [15:0] setpoint_distance;
  logic [11:0] error_deadband;
  logic [15:0] integral_limit;
  logic [7:0]  servo_center;
  logic [7:0]  servo_low;
  logic [7:0]  servo_high;
  logic [8:0]  sonar_smoothing;
  logic [8:0]  servo_smoothing;

  // loop state
  logic [15:0]        smoothed_distance;
  logic [15:0]        previous_distance;
  logic signed [17:0] error_integral;
  logic [15:0]        smoothed_command;

  // per-item working registers
  state_t                   state;
  logic [ADC_BITS-1:0]      raw;
  logic [15:0]              ms;
  logic signed [17:0]       err;
  logic [1:0]               zone;
  logic signed [DER_W-1:0]  deriv;
  logic signed [23:0]       pid;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod_r;

  // divider
  state_t              div_ret;
  logic [DEN_W-1:0]    div_rem;
  logic [DIV_W-1:0]    div_quo;
  logic [DEN_W-1:0]    div_den;
  logic [CNT_W-1:0]    div_cnt;
  logic                div_neg;

  // reciprocal multiplication
  logic [RCPN_W-1:0]   rcp_num;
  logic                rcp_sec;

  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] prod;
  logic [8:0]               w_sonar;
  logic [8:0]               w_servo;
  logic [DEN_W:0]           rem_sh;
  logic [DEN_W+1:0]         rem_diff;
  logic signed [DIV_W:0]    qs;
  logic [DIV_W-1:0]         num_mag;
  logic signed [PROD_W-1:0] prod_abs;
  logic signed [DIV_W+1:0]  raw_dist;
  logic signed [17:0]       dist_step;
  logic signed [25:0]       cmd_in;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  sd_sm;
  logic signed [ACC_W-1:0]  pid_sh;
  logic signed [ACC_W-1:0]  cmd_sm;
  logic signed [ACC_W-1:0]  cmd_lo;
  logic signed [ACC_W-1:0]  cmd_hi;
  logic signed [ACC_W-1:0]  cmd;
  logic signed [17:0]       err_full;
  logic [16:0]              err_mag;
  logic signed [DIV_W+2:0]  int_sum;
  logic signed [DIV_W+2:0]  int_lim;
  logic                     out_free;
  logic [15:0]              rcp_hi;
  logic [15:0]              rcp_lo;
  logic signed [ACC_W-1:0]  rcp_sum;
  logic signed [ACC_W-1:0]  rcp_q;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign w_sonar = (sonar_smoothing > 9'd256) ? 9'd256 : sonar_smoothing;
  assign w_servo = (servo_smoothing > 9'd256) ? 9'd256 : servo_smoothing;

  assign rem_sh   = {div_rem, div_quo[DIV_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b0, div_den};
  assign qs       = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign prod_abs = (prod_r < 0) ? -prod_r : prod_r;
  assign num_mag  = prod_abs[DIV_W-1:0];

  assign rcp_hi  = rcp_sec ? RCP_SEC_HI : RCP_FS_HI;
  assign rcp_lo  = rcp_sec ? RCP_SEC_LO : RCP_FS_LO;
  assign rcp_sum = acc + ACC_W'(prod_r >>> 16);
  assign rcp_q   = acc >>> RCP_DROP;

  assign raw_dist  = (DIV_W+2)'(qs) - (DIV_W+2)'(DIST_OFFSET);
  assign dist_step = $signed({2'b0, previous_distance}) - $signed({2'b0, smoothed_distance});
  assign cmd_in    = 26'($signed({2'b0, servo_center, {FRACTION_BITS{1'b0}}})) + 26'(pid);
  assign acc_sum   = acc + ACC_W'(prod_r);
  assign sd_sm     = acc >>> 8;
  assign pid_sh    = acc >>> GAIN_SHIFT;
  assign cmd_sm    = acc >>> 8;
  assign cmd_lo    = ACC_W'({servo_low, {FRACTION_BITS{1'b0}}});
  assign cmd_hi    = ACC_W'({servo_high, {FRACTION_BITS{1'b0}}});
  assign err_full  = $signed({2'b0, setpoint_distance}) - $signed({2'b0, smoothed_distance});
  assign err_mag   = (err_full < 0) ? 17'(-err_full) : 17'(err_full);
  assign int_sum   = (DIV_W+3)'(error_integral) + (DIV_W+3)'(qs);
  assign int_lim   = (DIV_W+3)'({1'b0, integral_limit});

  always_comb begin
    cmd = cmd_sm;
    if (cmd < cmd_lo) cmd = cmd_lo;
    if (cmd > cmd_hi) cmd = cmd_hi;
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_RAW_MUL: begin
        ma = MA_W'({raw, {FRACTION_BITS{1'b0}}});
        mb = MB_W'(250);
      end
      S_RCP_HI: begin
        ma = MA_W'(rcp_num);
        mb = MB_W'(rcp_hi);
      end
      S_RCP_LO: begin
        ma = MA_W'(rcp_num);
        mb = MB_W'(rcp_lo);
      end
      S_SD_MUL1: begin
        ma = MA_W'(raw_dist);
        mb = MB_W'(w_sonar);
      end
      S_SD_MUL2: begin
        ma = MA_W'(smoothed_distance);
        mb = MB_W'(9'd256 - w_sonar);
      end
      S_INT_MUL: begin
        ma = MA_W'(err);
        mb = MB_W'(ms);
      end
      S_INT_UPD: begin
        ma = MA_W'(dist_step);
        mb = MB_W'(1000);
      end
      S_PID_P: begin
        ma = MA_W'(err);
        mb = MB_W'(gain_kp(zone));
      end
      S_PID_I: begin
        ma = MA_W'(error_integral);
        mb = MB_W'(gain_ki(zone));
      end
      S_PID_D: begin
        ma = MA_W'(deriv);
        mb = MB_W'(gain_kd(zone));
      end
      S_CMD_MUL1: begin
        ma = MA_W'(cmd_in);
        mb = MB_W'(w_servo);
      end
      S_CMD_MUL2: begin
        ma = MA_W'(smoothed_command);
        mb = MB_W'(9'd256 - w_servo);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk) begin
    prod_r <= prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint_distance <= 16'd14080;
      error_deadband    <= 12'd256;
      integral_limit    <= 16'd5120;
      servo_center      <= 8'd148;
      servo_low         <= 8'd120;
      servo_high        <= 8'd163;
      sonar_smoothing   <= 9'd51;
      servo_smoothing   <= 9'd51;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SETPOINT:   setpoint_distance <= cfg_data;
        REG_DEADBAND:   error_deadband    <= cfg_data[11:0];
        REG_INT_LIMIT:  integral_limit    <= cfg_data;
        REG_CENTER:     servo_center      <= cfg_data[7:0];
        REG_SERVO_LOW:  servo_low         <= cfg_data[7:0];
        REG_SERVO_HIGH: servo_high        <= cfg_data[7:0];
        REG_SONAR_SM:   sonar_smoothing   <= cfg_data[8:0];
        REG_SERVO_SM:   servo_smoothing   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      div_ret           <= S_IDLE;
      out_valid         <= 1'b0;
      smoothed_distance <= '0;
      previous_distance <= '0;
      error_integral    <= '0;
      smoothed_command  <= '0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            raw <= adc_sample[ADC_BITS-1:0];
            ms  <= elapsed_ms;
            if (elapsed_ms != 16'd0) state <= S_RAW_MUL;
          end
        end
        S_RAW_MUL: state <= S_RAW_DIV;
        S_RAW_DIV: begin
          rcp_num <= num_mag[RCPN_W-1:0];
          rcp_sec <= 1'b0;
          div_neg <= 1'b0;
          div_ret <= S_SD_MUL1;
          state   <= S_RCP_HI;
        end
        S_RCP_HI: state <= S_RCP_LO;
        S_RCP_LO: begin
          acc   <= ACC_W'(prod_r);
          state <= S_RCP_ADD;
        end
        S_RCP_ADD: begin
          acc   <= rcp_sum;
          state <= S_RCP_END;
        end
        S_RCP_END: begin
          div_quo <= rcp_q[DIV_W-1:0];
          state   <= div_ret;
        end
        S_DIV: begin
          if (!rem_diff[DEN_W+1]) begin
            div_rem <= rem_diff[DEN_W-1:0];
            div_quo <= {div_quo[DIV_W-2:0], 1'b1};
          end else begin
            div_rem <= rem_sh[DEN_W-1:0];
            div_quo <= {div_quo[DIV_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(DIV_W - 1)) state <= div_ret;
        end
        S_SD_MUL1: state <= S_SD_MUL2;
        S_SD_MUL2: begin
          acc   <= ACC_W'(prod_r);
          state <= S_SD_ADD;
        end
        S_SD_ADD: begin
          acc   <= acc_sum;
          state <= S_SD_UPD;
        end
        S_SD_UPD: begin
          if (sd_sm < DIST_MIN) smoothed_distance <= DIST_MIN[15:0];
          else if (sd_sm > DIST_MAX) smoothed_distance <= DIST_MAX[15:0];
          else smoothed_distance <= sd_sm[15:0];
          state <= S_ERR;
        end
        S_ERR: begin
          if (err_mag < {5'b0, error_deadband}) begin
            err  <= '0;
            zone <= ZONE_NEAR;
          end else begin
            err <= err_full;
            if (err_mag > ZONE_FAR_MAG) zone <= ZONE_FAR;
            else if (err_mag > ZONE_MID_MAG) zone <= ZONE_MID;
            else zone <= ZONE_NEAR;
          end
          state <= S_INT_MUL;
        end
        S_INT_MUL: state <= S_INT_DIV;
        S_INT_DIV: begin
          // divide by 1000 as a shift by three and a reciprocal of 125
          rcp_num <= num_mag[RCPN_W+2:3];
          rcp_sec <= 1'b1;
          div_neg <= prod_r < 0;
          div_ret <= S_INT_UPD;
          state   <= S_RCP_HI;
        end
        S_INT_UPD: begin
          if (int_sum < -int_lim) error_integral <= 18'(-int_lim);
          else if (int_sum > int_lim) error_integral <= 18'(int_lim);
          else error_integral <= 18'(int_sum);
          state <= S_DER_DIV;
        end
        S_DER_DIV: begin
          div_rem <= '0;
          div_quo <= num_mag;
          div_neg <= prod_r < 0;
          div_den <= DEN_W'(ms);
          div_cnt <= '0;
          div_ret <= S_PID_P;
          previous_distance <= smoothed_distance;
          state   <= S_DIV;
        end
        S_PID_P: begin
          deriv <= qs[DER_W-1:0];
          state <= S_PID_I;
        end
        S_PID_I: begin
          acc   <= ACC_W'(prod_r);
          state <= S_PID_D;
        end
        S_PID_D: begin
          acc   <= acc_sum;
          state <= S_PID_ADD;
        end
        S_PID_ADD: begin
          acc   <= acc_sum;
          state <= S_PID_SAT;
        end
        S_PID_SAT: begin
          if (pid_sh > PID_MAX) pid <= PID_MAX[23:0];
          else if (pid_sh < PID_MIN) pid <= PID_MIN[23:0];
          else pid <= pid_sh[23:0];
          state <= S_CMD_MUL1;
        end
        S_CMD_MUL1: state <= S_CMD_MUL2;
        S_CMD_MUL2: begin
          acc   <= ACC_W'(prod_r);
          state <= S_CMD_ADD;
        end
        S_CMD_ADD: begin
          acc   <= acc_sum;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            smoothed_command  <= cmd[15:0];
            servo_angle       <= cmd[FRACTION_BITS+7:FRACTION_BITS];
            filtered_distance <= smoothed_distance;
            control_error     <= err[16:0];
            pid_output        <= pid;
            gain_zone         <= zone;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
